// ===== rtl/erhc_pkg.sv =====
// Shared types, codes and constants for the event rate history counter.
package erhc_pkg;

   localparam int HISTORY_DEPTH_DEF = 16;
   localparam int TIME_W            = 48;
   localparam int WORD_W            = 32;
   localparam int CFG_W             = 5;
   localparam int WIN_W             = 5;
   localparam int DIV_W             = 48;
   localparam logic [TIME_W-1:0] MS_PER_SEC = 48'd1000;
   localparam logic [DIV_W-1:0]  MS_Q16     = 48'd65536000;

   typedef enum logic [1:0] {
      OP_COUNT = 2'd0,
      OP_START = 2'd1,
      OP_CLEAR = 2'd2,
      OP_QUERY = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      DIV_ELAPSED = 2'd0,
      DIV_AVG     = 2'd1,
      DIV_MIN     = 2'd2,
      DIV_MAX     = 2'd3
   } div_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MERGE,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [1:0]        operation;
      logic [TIME_W-1:0] timestamp;
      logic [WIN_W-1:0]  window_cycles;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] count_sum;
      logic [WORD_W-1:0] rate_average;
      logic [WORD_W-1:0] rate_minimum;
      logic [WORD_W-1:0] rate_maximum;
      logic [TIME_W-1:0] window_start;
   } rsp_type;

   typedef struct packed {
      logic    accept;
      logic    merge;
      logic    div_start;
      logic    div_capture;
      div_type div_sel;
      logic    load_rsp;
   } cmd_type;

   typedef struct packed {
      logic is_query;
      logic more;
      logic div_done;
   } status_type;

endpackage

// ===== rtl/event_rate_history_counter_core.sv =====
// Top level of the event rate history counter.
// Count, start-cycle and clear beats are accepted back to back while no
// query is in progress. A query beat walks the older records of its window,
// each through the registered read of the record store and a merge step, then
// turns the elapsed milliseconds into whole seconds (radix-16 compare and
// subtract by 1000), then runs three divisions (average, minimum and maximum
// rate) in turn on one shared restoring divider at one quotient bit per cycle.
// The result stays in an output register until taken, while non-query beats
// continue to be accepted.
module event_rate_history_counter_core #(
   parameter int HISTORY_DEPTH = erhc_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  erhc_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output erhc_pkg::rsp_type            rsp_data,
   input  logic                         csr_wr_en,
   input  logic [erhc_pkg::CFG_W-1:0]   csr_wr_data
);
   import erhc_pkg::*;

   cmd_type    cmd;
   status_type status;

   erhc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   erhc_dp #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status)
   );
endmodule

// ===== rtl/erhc_div.sv =====
// Restoring divider, one quotient bit per cycle.
module erhc_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [erhc_pkg::DIV_W-1:0]    num,
   input  logic [erhc_pkg::DIV_W-1:0]    den,
   output logic                          done,
   output logic [erhc_pkg::DIV_W-1:0]    quo
);
   import erhc_pkg::*;

   localparam int CW = $clog2(DIV_W);

   logic [DIV_W:0]   rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] den_ff;
   logic [CW-1:0]    cnt_ff;
   logic             busy_ff, done_ff;
   logic [DIV_W:0]   trial;

   always_comb begin
      trial  = {rem_ff[DIV_W-1:0], quo_ff[DIV_W-1]};
      rem_in = trial;
      quo_in = {quo_ff[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, den_ff}) begin
         rem_in    = trial - {1'b0, den_ff};
         quo_in[0] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(DIV_W-1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= num;
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;
endmodule

// ===== rtl/erhc_ctrl.sv =====
// Sequencer for query walks, divisions and the result register.
module erhc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  erhc_pkg::status_type   status,
   output erhc_pkg::cmd_type      cmd
);
   import erhc_pkg::*;

   state_type state_ff, state_in;
   div_type   sel_ff, sel_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= DIV_ELAPSED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.div_sel  = sel_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid && status.is_query) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (status.more) begin
               state_in = ST_MERGE;
            end else begin
               sel_in   = DIV_ELAPSED;
               state_in = ST_DIV_GO;
            end
         end
         ST_MERGE: begin
            cmd.merge = 1'b1;
            state_in  = ST_READ;
         end
         ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.div_capture = 1'b1;
               if (sel_ff == DIV_MAX) begin
                  state_in = ST_OUT;
               end else begin
                  sel_in   = div_type'(sel_ff + 2'd1);
                  state_in = ST_DIV_GO;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

// ===== rtl/erhc_dp.sv =====
// Record store, current cycle registers, query accumulators, seconds converter, divider and result register.
module erhc_dp #(
   parameter int HISTORY_DEPTH = erhc_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  erhc_pkg::req_type             req_data,
   output erhc_pkg::rsp_type             rsp_data,
   input  logic                          csr_wr_en,
   input  logic [erhc_pkg::CFG_W-1:0]    csr_wr_data,
   input  erhc_pkg::cmd_type             cmd,
   output erhc_pkg::status_type          status
);
   import erhc_pkg::*;

   localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
   localparam int CMP_W = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;
   localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(HISTORY_DEPTH);
   localparam int SEC_DIG   = 4;
   localparam int SEC_STEPS = TIME_W / SEC_DIG;
   localparam int REM_W     = 10;
   localparam int TRIAL_W   = REM_W + SEC_DIG;

   typedef struct packed {
      logic [TIME_W-1:0] start;
      logic [WORD_W-1:0] count;
      logic [WORD_W-1:0] min_iv;
      logic [WORD_W-1:0] max_iv;
   } rec_type;

   typedef struct packed {
      logic [WORD_W-1:0] sum;
      logic [TIME_W-1:0] oldest;
      logic              missing;
      logic [WORD_W-1:0] largest;
      logic [WORD_W-1:0] smallest;
   } acc_type;

   function automatic acc_type merge_rec(acc_type a, rec_type r);
      acc_type         o;
      logic [WORD_W:0] s;
      o      = a;
      s      = {1'b0, a.sum} + {1'b0, r.count};
      o.sum  = s[WORD_W] ? '1 : s[WORD_W-1:0];
      o.oldest = r.start;
      if (r.max_iv == '0) begin
         o.missing = 1'b1;
      end else if (r.max_iv > a.largest) begin
         o.largest = r.max_iv;
      end
      if (r.min_iv != '0 && (a.smallest == '0 || r.min_iv < a.smallest)) begin
         o.smallest = r.min_iv;
      end
      return o;
   endfunction

   function automatic logic [WORD_W-1:0] sat_q(logic [DIV_W-1:0] q);
      return (q[DIV_W-1:WORD_W] != '0) ? '1 : q[WORD_W-1:0];
   endfunction

   function automatic logic [TIME_W-1:0] abs_diff(logic [TIME_W-1:0] a,
                                                  logic [TIME_W-1:0] b);
      return (a >= b) ? (a - b) : (b - a);
   endfunction

   rec_type           mem [HISTORY_DEPTH];
   rec_type           mem_q_ff;
   rec_type           cur_ff, cur_in;
   logic [TIME_W-1:0] last_ff, last_in;
   logic              pend_ff, pend_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  stored_ff, stored_in;
   logic [CFG_W-1:0]  cfg_ff;
   acc_type           acc_ff;
   logic [TIME_W-1:0] ts_q_ff;
   logic [CNT_W-1:0]  n_ff, k_ff;
   logic [TIME_W-1:0] elapsed_ff;
   logic [WORD_W-1:0] avg_ff, rmin_ff, rmax_ff;
   rsp_type           rsp_ff;

   logic [CMP_W-1:0]  keep, stored_c, win_c, kdiff;
   logic              start_ok, write_rec;
   logic [TIME_W-1:0] d64;
   logic [WORD_W-1:0] d32;
   logic [IDX_W-1:0]  rd_idx;
   logic [DIV_W-1:0]  div_num, div_den, div_quo;
   logic              div_done;
   acc_type           acc_init;

   logic [TIME_W-1:0]  sec_num_ff, sec_quo_ff;
   logic [REM_W-1:0]   sec_rem_ff, sec_rem_in;
   logic [3:0]         sec_cnt_ff;
   logic               sec_busy_ff, sec_done_ff;
   logic [TRIAL_W-1:0] sec_trial, sec_sub;
   logic [SEC_DIG-1:0] sec_digit;
   logic               sec_start, div_start;

   assign keep     = (CMP_W'(cfg_ff) > DEPTH_C) ? DEPTH_C : CMP_W'(cfg_ff);
   assign stored_c = CMP_W'(stored_ff);
   assign win_c    = CMP_W'(req_data.window_cycles);
   assign start_ok = (keep != '0) && (req_data.timestamp > cur_ff.start);
   assign write_rec = cmd.accept && (req_data.operation == OP_START) && start_ok;
   assign d64      = abs_diff(req_data.timestamp, last_ff);
   assign d32      = (d64[TIME_W-1:WORD_W] != '0) ? '1 : d64[WORD_W-1:0];

   always_comb begin
      if (CMP_W'(idx_ff) >= CMP_W'(k_ff)) begin
         kdiff = CMP_W'(idx_ff) - CMP_W'(k_ff);
      end else begin
         kdiff = CMP_W'(idx_ff) + DEPTH_C - CMP_W'(k_ff);
      end
      rd_idx = kdiff[IDX_W-1:0];
   end

   always_comb begin
      cur_in    = cur_ff;
      last_in   = last_ff;
      pend_in   = pend_ff;
      idx_in    = idx_ff;
      stored_in = stored_ff;
      if (cmd.accept) begin
         case (req_data.operation)
            OP_COUNT: begin
               if (cur_ff.count != '1) begin
                  cur_in.count = cur_ff.count + 1'b1;
               end
               if (!pend_ff) begin
                  if (cur_ff.max_iv == '0 || d32 > cur_ff.max_iv) begin
                     cur_in.max_iv = d32;
                  end
                  if (cur_ff.min_iv == '0 || d32 < cur_ff.min_iv) begin
                     cur_in.min_iv = d32;
                  end
               end
               last_in = req_data.timestamp;
               pend_in = 1'b0;
            end
            OP_START: begin
               if (start_ok) begin
                  idx_in = (idx_ff == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : idx_ff + 1'b1;
                  stored_in = (stored_c > keep - 1'b1) ? CNT_W'(keep) : stored_ff + 1'b1;
                  cur_in  = '{start: req_data.timestamp, default: '0};
                  last_in = '0;
                  pend_in = 1'b1;
               end
            end
            OP_CLEAR: begin
               idx_in    = '0;
               stored_in = CNT_W'(1);
               cur_in    = '{start: req_data.timestamp, default: '0};
               last_in   = '0;
               pend_in   = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff    <= '0;
         last_ff   <= '0;
         pend_ff   <= 1'b1;
         idx_ff    <= '0;
         stored_ff <= CNT_W'(1);
         cfg_ff    <= CFG_W'(1);
      end else begin
         cur_ff    <= cur_in;
         last_ff   <= last_in;
         pend_ff   <= pend_in;
         idx_ff    <= idx_in;
         stored_ff <= stored_in;
         if (csr_wr_en) begin
            cfg_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (write_rec) begin
         mem[idx_ff] <= cur_ff;
      end
      mem_q_ff <= mem[rd_idx];
   end

   assign acc_init = merge_rec('{missing: 1'b0, default: '0}, cur_ff);

   always_ff @(posedge clock) begin
      if (cmd.accept && req_data.operation == OP_QUERY) begin
         acc_ff  <= acc_init;
         ts_q_ff <= req_data.timestamp;
         k_ff    <= CNT_W'(1);
         n_ff    <= (win_c == '0 || win_c > stored_c) ? stored_ff : CNT_W'(win_c);
      end else if (cmd.merge) begin
         acc_ff <= merge_rec(acc_ff, mem_q_ff);
         k_ff   <= k_ff + 1'b1;
      end
   end

   // elapsed ms to whole seconds: radix-16 compare and subtract against multiples of 1000
   always_comb begin
      sec_trial = {sec_rem_ff, sec_num_ff[TIME_W-1 -: SEC_DIG]};
      sec_digit = '0;
      sec_sub   = '0;
      for (int j = 1; j < (1 << SEC_DIG); j++) begin
         if (sec_trial >= TRIAL_W'(MS_PER_SEC * j)) begin
            sec_digit = SEC_DIG'(j);
            sec_sub   = TRIAL_W'(MS_PER_SEC * j);
         end
      end
      sec_rem_in = REM_W'(sec_trial - sec_sub);
   end

   assign sec_start = cmd.div_start && (cmd.div_sel == DIV_ELAPSED);
   assign div_start = cmd.div_start && (cmd.div_sel != DIV_ELAPSED);

   always_ff @(posedge clock) begin
      if (reset) begin
         sec_busy_ff <= 1'b0;
         sec_done_ff <= 1'b0;
         sec_cnt_ff  <= '0;
      end else begin
         sec_done_ff <= 1'b0;
         if (sec_start) begin
            sec_busy_ff <= 1'b1;
            sec_cnt_ff  <= '0;
         end else if (sec_busy_ff) begin
            sec_cnt_ff <= sec_cnt_ff + 1'b1;
            if (sec_cnt_ff == 4'(SEC_STEPS - 1)) begin
               sec_busy_ff <= 1'b0;
               sec_done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sec_start) begin
         sec_rem_ff <= '0;
         sec_num_ff <= abs_diff(acc_ff.oldest, ts_q_ff);
         sec_quo_ff <= '0;
      end else if (sec_busy_ff) begin
         sec_rem_ff <= sec_rem_in;
         sec_num_ff <= {sec_num_ff[TIME_W-SEC_DIG-1:0], {SEC_DIG{1'b0}}};
         sec_quo_ff <= {sec_quo_ff[TIME_W-SEC_DIG-1:0], sec_digit};
      end
   end

   always_comb begin
      case (cmd.div_sel)
         DIV_ELAPSED: begin
            div_num = '0;
            div_den = '0;
         end
         DIV_AVG: begin
            div_num = {acc_ff.sum, 16'h0000};
            div_den = elapsed_ff;
         end
         DIV_MIN: begin
            div_num = MS_Q16;
            div_den = DIV_W'(acc_ff.largest);
         end
         default: begin
            div_num = MS_Q16;
            div_den = DIV_W'(acc_ff.smallest);
         end
      endcase
   end

   erhc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_ff @(posedge clock) begin
      if (cmd.div_capture) begin
         case (cmd.div_sel)
            DIV_ELAPSED: elapsed_ff <= sec_quo_ff;
            DIV_AVG:     avg_ff  <= (elapsed_ff == '0) ? '0 : sat_q(div_quo);
            DIV_MIN:     rmin_ff <= (acc_ff.missing || acc_ff.largest == '0) ? '0
                                                                   : sat_q(div_quo);
            default:     rmax_ff <= (acc_ff.smallest == '0) ? '0 : sat_q(div_quo);
         endcase
      end
      if (cmd.load_rsp) begin
         rsp_ff <= '{count_sum:    acc_ff.sum,
                     rate_average: avg_ff,
                     rate_minimum: rmin_ff,
                     rate_maximum: rmax_ff,
                     window_start: acc_ff.oldest};
      end
   end

   assign status.is_query = (req_data.operation == OP_QUERY);
   assign status.more     = (k_ff < n_ff);
   assign status.div_done = (cmd.div_sel == DIV_ELAPSED) ? sec_done_ff : div_done;
   assign rsp_data        = rsp_ff;
endmodule

// ===== rtl/erhc_chk.sv =====
// Port-level checks for the event rate history counter, bound to the top level.
module erhc_chk (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input erhc_pkg::req_type            req_data,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input erhc_pkg::rsp_type            rsp_data,
   input logic                         csr_wr_en,
   input logic [erhc_pkg::CFG_W-1:0]   csr_wr_data
);
   import erhc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat dropped or changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_zero_avg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.count_sum == '0 |-> rsp_data.rate_average == '0)
      else $error("nonzero average rate with no events");

   a_busy_query: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.operation == OP_QUERY |=> !req_ready)
      else $error("request accepted during query");
endmodule

bind event_rate_history_counter_core erhc_chk u_chk (.*);

// ===== sim/tb.sv =====
// Testbench for event_rate_history_counter_core: directed beats, predicted results, random traffic.
module tb;
   import erhc_pkg::*;

   localparam int DEPTH = 16;
   localparam int WATCHDOG_LIMIT = 20000;

   class rate_scoreboard;
      logic [47:0] start_time [DEPTH];
      logic [31:0] event_count [DEPTH];
      logic [31:0] min_gap [DEPTH];
      logic [31:0] max_gap [DEPTH];
      logic [47:0] last_time;
      bit          first_pending;
      int          newest;
      int          stored;
      int          keep_cfg;
      rsp_type     pending_rsp [$];
      int          errors;
      int          checked;

      function void clear_all();
         for (int i = 0; i < DEPTH; i++) begin
            open_rec(i, 48'd0);
         end
         newest = 0;
         stored = 1;
         keep_cfg = 1;
      endfunction

      function void open_rec(int idx, logic [47:0] ts);
         start_time[idx] = ts;
         event_count[idx] = 0;
         min_gap[idx] = 0;
         max_gap[idx] = 0;
         last_time = 0;
         first_pending = 1;
      endfunction

      function logic [31:0] q16(logic [63:0] num, logic [63:0] den);
         logic [79:0] q;
         if (den == 0) return 0;
         q = {num, 16'd0} / den;
         return (q > 80'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
      endfunction

      function void note_beat(req_type r);
         int cur;
         int keep;
         logic [47:0] d48;
         logic [31:0] d;
         cur = newest;
         case (op_type'(r.operation))
            OP_COUNT: begin
               if (event_count[cur] != 32'hFFFF_FFFF) event_count[cur]++;
               if (!first_pending) begin
                  d48 = (r.timestamp >= last_time) ? r.timestamp - last_time
                                                   : last_time - r.timestamp;
                  d = (d48 > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : d48[31:0];
                  if (max_gap[cur] == 0 || d > max_gap[cur]) max_gap[cur] = d;
                  if (min_gap[cur] == 0 || d < min_gap[cur]) min_gap[cur] = d;
               end
               last_time = r.timestamp;
               first_pending = 0;
            end
            OP_START: begin
               keep = (keep_cfg > DEPTH) ? DEPTH : keep_cfg;
               if (keep > 0 && r.timestamp > start_time[cur]) begin
                  newest = (cur + 1) % DEPTH;
                  if (stored > keep - 1) stored = keep - 1;
                  stored++;
                  open_rec(newest, r.timestamp);
               end
            end
            OP_CLEAR: begin
               newest = 0;
               stored = 1;
               open_rec(0, r.timestamp);
            end
            default: begin
               int n;
               int idx;
               logic [63:0] sum;
               logic [47:0] oldest;
               logic [47:0] elapsed;
               logic [31:0] largest;
               logic [31:0] smallest;
               bit missing;
               rsp_type e;
               n = r.window_cycles;
               sum = 0;
               oldest = 0;
               largest = 0;
               smallest = 0;
               missing = 0;
               if (n == 0 || n > stored) n = stored;
               for (int k = 0; k < n; k++) begin
                  idx = (cur + DEPTH - k) % DEPTH;
                  sum += event_count[idx];
                  if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
                  oldest = start_time[idx];
                  if (max_gap[idx] == 0) missing = 1;
                  else if (max_gap[idx] > largest) largest = max_gap[idx];
                  if (min_gap[idx] != 0 && (smallest == 0 || min_gap[idx] < smallest))
                     smallest = min_gap[idx];
               end
               elapsed = ((oldest >= r.timestamp) ? oldest - r.timestamp
                                                  : r.timestamp - oldest) / 1000;
               e.count_sum = sum[31:0];
               e.rate_average = q16(sum, elapsed);
               e.rate_minimum = missing ? 32'd0 : q16(1000, largest);
               e.rate_maximum = q16(1000, smallest);
               e.window_start = oldest;
               pending_rsp = {pending_rsp, e};
            end
         endcase
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         $display("mismatch %s: got %0h expected %0h", what, got, want);
         errors++;
      endtask

      task check_beat(rsp_type g);
         rsp_type e;
         checked++;
         if (pending_rsp.size() == 0) begin
            report("unexpected beat", 0, 0);
            return;
         end
         e = pending_rsp.pop_front();
         if (g.count_sum !== e.count_sum) report("count_sum", g.count_sum, e.count_sum);
         if (g.rate_average !== e.rate_average)
            report("rate_average", g.rate_average, e.rate_average);
         if (g.rate_minimum !== e.rate_minimum)
            report("rate_minimum", g.rate_minimum, e.rate_minimum);
         if (g.rate_maximum !== e.rate_maximum)
            report("rate_maximum", g.rate_maximum, e.rate_maximum);
         if (g.window_start !== e.window_start)
            report("window_start", g.window_start, e.window_start);
      endtask
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_ready;
   rsp_type    rsp_data;
   logic       csr_wr_en;
   logic [4:0] csr_wr_data;

   rate_scoreboard sb;
   int  send_idle_pct;
   int  recv_stall_pct;
   int  quiet_cycles;
   logic [47:0] now_ms;
   int  queries;

   event_rate_history_counter_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         if (rsp_valid && rsp_ready) sb.check_beat(rsp_data);
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[event_rate_history_counter_core] ERROR");
         $finish;
      end
   end

   task send(op_type op, logic [47:0] ts, logic [4:0] win);
      req_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      r.operation = op;
      r.timestamp = ts;
      r.window_cycles = win;
      req_valid <= 1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_beat(r);
      if (op == OP_QUERY) queries++;
   endtask

   task drain();
      req_valid <= 0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task write_keep(int v);
      drain();
      csr_wr_en <= 1;
      csr_wr_data <= 5'(v);
      @(posedge clock);
      csr_wr_en <= 0;
      sb.keep_cfg = v;
      @(posedge clock);
   endtask

   task random_item();
      int p;
      logic [47:0] ts;
      p = $urandom_range(99);
      now_ms += $urandom_range(3) == 0 ? $urandom_range(5000) : $urandom_range(40);
      ts = now_ms;
      if ($urandom_range(49) == 0) ts = 48'({$urandom, $urandom});
      if (p < 55) send(OP_COUNT, ts, 0);
      else if (p < 72) send(OP_START, ($urandom_range(9) == 0) ? ts - 10 : ts, 0);
      else if (p < 75) send(OP_CLEAR, ts, 0);
      else send(OP_QUERY, ts, 5'($urandom_range(31)));
   endtask

   initial begin
      sb = new();
      sb.clear_all();
      sb.errors = 0;
      sb.checked = 0;
      queries = 0;
      quiet_cycles = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset = 1;
      req_valid = 0;
      req_data = '0;
      csr_wr_en = 0;
      csr_wr_data = 0;
      now_ms = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed
      send(OP_QUERY, 48'd0, 0);
      send(OP_COUNT, 48'd100, 0);
      send(OP_COUNT, 48'd100, 0);
      send(OP_COUNT, 48'd350, 0);
      send(OP_QUERY, 48'd2500, 5'd31);
      write_keep(16);
      send(OP_START, 48'd0, 0);
      send(OP_START, 48'd3000, 0);
      send(OP_COUNT, 48'hFFFF_FFFF_FFFF, 0);
      send(OP_COUNT, 48'd1, 0);
      send(OP_COUNT, 48'd5, 0);
      send(OP_QUERY, 48'hFFFF_FFFF_FFFF, 5'd1);
      send(OP_QUERY, 48'd1000, 5'd0);
      write_keep(0);
      send(OP_START, 48'd90000, 0);
      send(OP_QUERY, 48'd0, 5'd16);
      send(OP_CLEAR, 48'd500, 0);
      send(OP_COUNT, 48'd600, 0);
      send(OP_QUERY, 48'd100, 5'd2);
      send(OP_CLEAR, 48'hAAAA_AAAA_AAAA, 0);
      send(OP_QUERY, 48'h5555_5555_5555, 5'd21);
      now_ms = 48'd1000;

      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
            default: begin send_idle_pct = 35; recv_stall_pct = 35; end
         endcase
         write_keep((ph == 4) ? 1 : (ph == 7) ? 31 : $urandom_range(16));
         send(OP_CLEAR, now_ms, 0);
         for (int i = 0; i < 155; i++) begin
            random_item();
            if (i == 80) drain();
         end
      end

      drain();
      $display("covered %0d queries, %0d results checked, 8 config phases",
               queries, sb.checked);
      if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
         $display("[event_rate_history_counter_core] OK");
      end else begin
         $display("[event_rate_history_counter_core] ERROR");
      end
      $finish;
   end
endmodule
